// ===== rtl/cct_pkg.sv =====
// ----------------------------------------------------------------------------
// cct_pkg: shared types and codes of the character class tokenizer
// Byte kinds, run and token class codes, queue items and output clamps.
// ----------------------------------------------------------------------------
package cct_pkg;

   localparam int KIND_BITS   = 3;
   localparam int CLASS_BITS  = 3;
   localparam int OUT_OFFSET_BITS = 32;
   localparam int OUT_LINE_BITS   = 24;

   localparam int BYTE_QUEUE_DEPTH = 4;
   localparam int RSP_QUEUE_DEPTH  = 4;

   localparam logic [KIND_BITS-1:0] KIND_SPACE    = 3'd0;
   localparam logic [KIND_BITS-1:0] KIND_NEWLINE  = 3'd1;
   localparam logic [KIND_BITS-1:0] KIND_DIGIT    = 3'd2;
   localparam logic [KIND_BITS-1:0] KIND_LETTER   = 3'd3;
   localparam logic [KIND_BITS-1:0] KIND_RESERVED = 3'd4;
   localparam logic [KIND_BITS-1:0] KIND_OTHER    = 3'd5;

   localparam logic [1:0] RUN_NONE  = 2'd0;
   localparam logic [1:0] RUN_DIGIT = 2'd1;
   localparam logic [1:0] RUN_WORD  = 2'd2;
   localparam logic [1:0] RUN_OTHER = 2'd3;

   localparam logic [CLASS_BITS-1:0] CLASS_DIGITS   = 3'd0;
   localparam logic [CLASS_BITS-1:0] CLASS_RESERVED = 3'd1;
   localparam logic [CLASS_BITS-1:0] CLASS_WORD     = 3'd2;
   localparam logic [CLASS_BITS-1:0] CLASS_OTHER    = 3'd3;
   localparam logic [CLASS_BITS-1:0] CLASS_END      = 3'd4;

   typedef struct packed {
      logic [KIND_BITS-1:0] kind;
      logic                 final_byte;
   } byte_item_type;

   typedef struct packed {
      logic [CLASS_BITS-1:0]      token_class;
      logic [OUT_OFFSET_BITS-1:0] start_offset;
      logic [OUT_OFFSET_BITS-1:0] token_length;
      logic [OUT_LINE_BITS-1:0]   line_number;
      logic [OUT_OFFSET_BITS-1:0] column_number;
      logic                       last_of_run;
   } rsp_item_type;

   localparam int BYTE_ITEM_BITS = $bits(byte_item_type);
   localparam int RSP_ITEM_BITS  = $bits(rsp_item_type);

   function automatic logic [OUT_OFFSET_BITS-1:0] clamp_offset(input logic [64:0] v);
      return (|v[64:OUT_OFFSET_BITS]) ? '1 : v[OUT_OFFSET_BITS-1:0];
   endfunction

   function automatic logic [OUT_LINE_BITS-1:0] clamp_line(input logic [32:0] v);
      return (|v[32:OUT_LINE_BITS]) ? '1 : v[OUT_LINE_BITS-1:0];
   endfunction

   function automatic logic [CLASS_BITS-1:0] run_to_class(input logic [1:0] rc);
      logic [CLASS_BITS-1:0] c;
      unique case (rc)
         RUN_DIGIT: c = CLASS_DIGITS;
         RUN_WORD:  c = CLASS_WORD;
         default:   c = CLASS_OTHER;
      endcase
      return c;
   endfunction

endpackage

// ===== rtl/character_class_tokenizer.sv =====
// ----------------------------------------------------------------------------
// character_class_tokenizer: streaming lexical tokenizer
// Splits a byte stream into digit runs, reserved bytes, words and other runs.
//
// Input queue: present req_text_byte and req_final_byte with push; a byte is
// taken at a clock edge where push is high and full is low. A high
// req_final_byte ends the text: any pending token is flushed, an end marker
// follows, and the next byte starts a new text from offset zero, line one.
// Result queue: while empty is low the oldest result sits on the rsp_ ports
// and is taken at an edge where pop is high. rsp_last_of_run marks the last
// result caused by one byte.
// Bytes flow at one per cycle while each causes at most one result and the
// result queue has room; a byte that causes several results holds the back
// end until all have left its sequencer, one per cycle while the result queue
// is not full. A four entry byte queue and a four entry result queue decouple
// the sides; a stalled receiver only backs up into full once both are filled.
// Reset is synchronous and empties both queues and restores the counters.
// ----------------------------------------------------------------------------
module character_class_tokenizer #(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS   = 24
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic [7:0]  req_text_byte,
   input  logic        req_final_byte,
   output logic        empty,
   input  logic        pop,
   output logic [2:0]  rsp_token_class,
   output logic [31:0] rsp_start_offset,
   output logic [31:0] rsp_token_length,
   output logic [23:0] rsp_line_number,
   output logic [31:0] rsp_column_number,
   output logic        rsp_last_of_run
);
   import cct_pkg::*;

   logic          head_valid;
   byte_item_type head_item;
   logic          head_pop;
   logic          rsp_push;
   rsp_item_type  back_item;
   logic          rsp_full;
   rsp_item_type  out_item;

   cct_front u_front (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_text_byte  (req_text_byte),
      .req_final_byte (req_final_byte),
      .head_valid     (head_valid),
      .head_item      (head_item),
      .head_pop       (head_pop)
   );

   cct_back #(
      .OFFSET_BITS (OFFSET_BITS),
      .LINE_BITS   (LINE_BITS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .head_pop   (head_pop),
      .rsp_push   (rsp_push),
      .rsp_item   (back_item),
      .rsp_full   (rsp_full)
   );

   cct_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .wr_push   (rsp_push),
      .wr_item   (back_item),
      .wr_full   (rsp_full),
      .empty     (empty),
      .pop       (pop),
      .head_item (out_item)
   );

   assign rsp_token_class   = out_item.token_class;
   assign rsp_start_offset  = out_item.start_offset;
   assign rsp_token_length  = out_item.token_length;
   assign rsp_line_number   = out_item.line_number;
   assign rsp_column_number = out_item.column_number;
   assign rsp_last_of_run   = out_item.last_of_run;

endmodule

// ===== rtl/cct_front.sv =====
// ----------------------------------------------------------------------------
// cct_front: byte intake and classification
// Classifies each accepted byte and holds it in a short queue for the back end.
// ----------------------------------------------------------------------------
module cct_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   output logic                   full,
   input  logic [7:0]             req_text_byte,
   input  logic                   req_final_byte,
   output logic                   head_valid,
   output cct_pkg::byte_item_type head_item,
   input  logic                   head_pop
);
   import cct_pkg::*;

   localparam int PTR_W = $clog2(BYTE_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(BYTE_QUEUE_DEPTH + 1);

   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_NEWLINE = 8'h0A;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_LBRACK  = 8'h5B;
   localparam logic [7:0] CH_RBRACK  = 8'h5D;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_COMMA   = 8'h2C;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOW_A   = 8'h61;
   localparam logic [7:0] CH_LOW_Z   = 8'h7A;
   localparam logic [7:0] CH_UP_A    = 8'h41;
   localparam logic [7:0] CH_UP_Z    = 8'h5A;

   byte_item_type        mem_ff [BYTE_QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   byte_item_type        new_item;
   logic                 accept;
   logic                 do_pop;

   always_comb begin
      new_item.final_byte = req_final_byte;
      if (req_text_byte == CH_NEWLINE) begin
         new_item.kind = KIND_NEWLINE;
      end else if (req_text_byte == CH_SPACE || req_text_byte == CH_TAB) begin
         new_item.kind = KIND_SPACE;
      end else if (req_text_byte >= CH_ZERO && req_text_byte <= CH_NINE) begin
         new_item.kind = KIND_DIGIT;
      end else if ((req_text_byte >= CH_LOW_A && req_text_byte <= CH_LOW_Z) ||
                   (req_text_byte >= CH_UP_A && req_text_byte <= CH_UP_Z)) begin
         new_item.kind = KIND_LETTER;
      end else if (req_text_byte == CH_LBRACK || req_text_byte == CH_RBRACK ||
                   req_text_byte == CH_LPAREN || req_text_byte == CH_RPAREN ||
                   req_text_byte == CH_COMMA) begin
         new_item.kind = KIND_RESERVED;
      end else begin
         new_item.kind = KIND_OTHER;
      end
   end

   assign full       = (count_ff == CNT_W'(BYTE_QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = mem_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign do_pop     = head_pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(BYTE_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(BYTE_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (accept && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!accept && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_ff[wr_ptr_ff] <= new_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(BYTE_QUEUE_DEPTH))
      else $error("byte queue count out of range");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (accept && !do_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("byte queue count missed an item");
   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      head_pop |-> head_valid)
      else $error("byte queue popped while empty");
`endif

endmodule

// ===== rtl/cct_back.sv =====
// ----------------------------------------------------------------------------
// cct_back: token state and result sequencing
// Tracks the pending run and position counters and emits one result per cycle while the result queue is not full.
// ----------------------------------------------------------------------------
module cct_back #(
   parameter int OFFSET_BITS = 32,
   parameter int LINE_BITS   = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   head_valid,
   input  cct_pkg::byte_item_type head_item,
   output logic                   head_pop,
   output logic                   rsp_push,
   output cct_pkg::rsp_item_type  rsp_item,
   input  logic                   rsp_full
);
   import cct_pkg::*;

   localparam int CW = OFFSET_BITS + 1;

   logic [1:0]             run_class_ff, run_class_in;
   logic [OFFSET_BITS-1:0] byte_offset_ff, byte_offset_in;
   logic [OFFSET_BITS-1:0] pending_start_ff, pending_start_in;
   logic [LINE_BITS-1:0]   line_count_ff, line_count_in;
   logic [OFFSET_BITS-1:0] line_start_ff, line_start_in;
   logic [LINE_BITS-1:0]   pending_line_ff, pending_line_in;
   logic [CW-1:0]          pending_column_ff, pending_column_in;
   logic [3:0]             sent_ff, sent_in;

   logic [OFFSET_BITS-1:0] next_offset;
   logic                   cont;
   logic [1:0]             run2;
   logic [OFFSET_BITS-1:0] ps2, ls2;
   logic [LINE_BITS-1:0]   pl2, lc2;
   logic [CW-1:0]          pc2, cur_column, end_column;
   logic                   blank_byte;

   logic                   slot_valid [4];
   rsp_item_type           slot_item  [4];
   logic                   sel_found;
   logic [1:0]             sel_idx;
   logic [3:0]             rest;
   logic                   more;

   assign next_offset = (&byte_offset_ff) ? byte_offset_ff : byte_offset_ff + 1'b1;
   assign blank_byte  = (head_item.kind == KIND_SPACE) || (head_item.kind == KIND_NEWLINE);
   assign cur_column  = CW'(byte_offset_ff) - CW'(line_start_ff) + 1'b1;

   always_comb begin
      unique case (run_class_ff)
         RUN_DIGIT: cont = (head_item.kind == KIND_DIGIT);
         RUN_WORD:  cont = (head_item.kind == KIND_DIGIT) || (head_item.kind == KIND_LETTER);
         RUN_OTHER: cont = (head_item.kind == KIND_OTHER);
         default:   cont = 1'b0;
      endcase
   end

   // state after the byte itself, before any end of text flush
   always_comb begin
      run2 = run_class_ff;
      ps2  = pending_start_ff;
      pl2  = pending_line_ff;
      pc2  = pending_column_ff;
      lc2  = line_count_ff;
      ls2  = line_start_ff;
      if (!cont) begin
         run2 = RUN_NONE;
         if (head_item.kind == KIND_NEWLINE) begin
            lc2 = (&line_count_ff) ? line_count_ff : line_count_ff + 1'b1;
            ls2 = next_offset;
         end else if (!blank_byte && head_item.kind != KIND_RESERVED) begin
            unique case (head_item.kind)
               KIND_DIGIT:  run2 = RUN_DIGIT;
               KIND_LETTER: run2 = RUN_WORD;
               default:     run2 = RUN_OTHER;
            endcase
            ps2 = byte_offset_ff;
            pl2 = line_count_ff;
            pc2 = cur_column;
         end
      end
   end

   assign end_column = CW'(next_offset) - CW'(ls2) + 1'b1;

   // candidate results in emission order
   always_comb begin
      slot_valid[0] = !cont && (run_class_ff != RUN_NONE);
      slot_item[0].token_class   = run_to_class(run_class_ff);
      slot_item[0].start_offset  = clamp_offset(65'(pending_start_ff));
      slot_item[0].token_length  = clamp_offset(65'(byte_offset_ff - pending_start_ff));
      slot_item[0].line_number   = clamp_line(33'(pending_line_ff));
      slot_item[0].column_number = clamp_offset(65'(pending_column_ff));
      slot_item[0].last_of_run   = 1'b0;

      slot_valid[1] = !cont && (head_item.kind == KIND_RESERVED);
      slot_item[1].token_class   = CLASS_RESERVED;
      slot_item[1].start_offset  = clamp_offset(65'(byte_offset_ff));
      slot_item[1].token_length  = OUT_OFFSET_BITS'(1);
      slot_item[1].line_number   = clamp_line(33'(line_count_ff));
      slot_item[1].column_number = clamp_offset(65'(cur_column));
      slot_item[1].last_of_run   = 1'b0;

      slot_valid[2] = head_item.final_byte && (run2 != RUN_NONE);
      slot_item[2].token_class   = run_to_class(run2);
      slot_item[2].start_offset  = clamp_offset(65'(ps2));
      slot_item[2].token_length  = clamp_offset(65'(next_offset - ps2));
      slot_item[2].line_number   = clamp_line(33'(pl2));
      slot_item[2].column_number = clamp_offset(65'(pc2));
      slot_item[2].last_of_run   = 1'b0;

      slot_valid[3] = head_item.final_byte;
      slot_item[3].token_class   = CLASS_END;
      slot_item[3].start_offset  = clamp_offset(65'(next_offset));
      slot_item[3].token_length  = '0;
      slot_item[3].line_number   = clamp_line(33'(lc2));
      slot_item[3].column_number = clamp_offset(65'(end_column));
      slot_item[3].last_of_run   = 1'b0;
   end

   always_comb begin
      sel_found = 1'b0;
      sel_idx   = '0;
      for (int i = 0; i < 4; i++) begin
         if (!sel_found && slot_valid[i] && !sent_ff[i]) begin
            sel_found = 1'b1;
            sel_idx   = 2'(i);
         end
      end
      rest = {slot_valid[3], slot_valid[2], slot_valid[1], slot_valid[0]}
             & ~sent_ff & ~(4'b0001 << sel_idx);
      more = |rest;
   end

   always_comb begin
      rsp_item             = slot_item[sel_idx];
      rsp_item.last_of_run = !more;
   end

   assign rsp_push = head_valid && sel_found && !rsp_full;
   assign head_pop = head_valid && (!sel_found || (rsp_push && !more));

   always_comb begin
      sent_in           = sent_ff;
      run_class_in      = run_class_ff;
      byte_offset_in    = byte_offset_ff;
      pending_start_in  = pending_start_ff;
      line_count_in     = line_count_ff;
      line_start_in     = line_start_ff;
      pending_line_in   = pending_line_ff;
      pending_column_in = pending_column_ff;
      if (head_pop) begin
         sent_in = '0;
         if (head_item.final_byte) begin
            run_class_in      = RUN_NONE;
            byte_offset_in    = '0;
            pending_start_in  = '0;
            line_count_in     = LINE_BITS'(1);
            line_start_in     = '0;
            pending_line_in   = LINE_BITS'(1);
            pending_column_in = CW'(1);
         end else begin
            run_class_in      = run2;
            byte_offset_in    = next_offset;
            pending_start_in  = ps2;
            line_count_in     = lc2;
            line_start_in     = ls2;
            pending_line_in   = pl2;
            pending_column_in = pc2;
         end
      end else if (rsp_push) begin
         sent_in = sent_ff | (4'b0001 << sel_idx);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sent_ff           <= '0;
         run_class_ff      <= RUN_NONE;
         byte_offset_ff    <= '0;
         pending_start_ff  <= '0;
         line_count_ff     <= LINE_BITS'(1);
         line_start_ff     <= '0;
         pending_line_ff   <= LINE_BITS'(1);
         pending_column_ff <= CW'(1);
      end else begin
         sent_ff           <= sent_in;
         run_class_ff      <= run_class_in;
         byte_offset_ff    <= byte_offset_in;
         pending_start_ff  <= pending_start_in;
         line_count_ff     <= line_count_in;
         line_start_ff     <= line_start_in;
         pending_line_ff   <= pending_line_in;
         pending_column_ff <= pending_column_in;
      end
   end

`ifndef NO_ASSERTIONS
   a_push_not_full: assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> !rsp_full)
      else $error("result pushed into full queue");
   a_end_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_push && rsp_item.token_class == CLASS_END) |-> rsp_item.last_of_run)
      else $error("end marker not flagged last");
   a_final_resets: assert property (@(posedge clock) disable iff (reset)
      (head_pop && head_item.final_byte) |=>
         (byte_offset_ff == '0 && run_class_ff == RUN_NONE && sent_ff == '0))
      else $error("state not restored after final byte");
   a_line_start_order: assert property (@(posedge clock) disable iff (reset)
      line_start_ff <= byte_offset_ff)
      else $error("line start past current offset");
`endif

endmodule

// ===== rtl/cct_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// cct_rsp_queue: result queue
// Holds finished result items until the receiver pops them.
// ----------------------------------------------------------------------------
module cct_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_push,
   input  cct_pkg::rsp_item_type wr_item,
   output logic                  wr_full,
   output logic                  empty,
   input  logic                  pop,
   output cct_pkg::rsp_item_type head_item
);
   import cct_pkg::*;

   localparam int PTR_W = $clog2(RSP_QUEUE_DEPTH);
   localparam int CNT_W = $clog2(RSP_QUEUE_DEPTH + 1);

   rsp_item_type     mem_ff [RSP_QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign wr_full   = (count_ff == CNT_W'(RSP_QUEUE_DEPTH));
   assign empty     = (count_ff == '0);
   assign head_item = mem_ff[rd_ptr_ff];
   assign do_push   = wr_push && !wr_full;
   assign do_pop    = pop && !empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(RSP_QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(RSP_QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

`ifndef NO_ASSERTIONS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(RSP_QUEUE_DEPTH))
      else $error("result queue count out of range");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_W'(RSP_QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("result queue pointers disagree with count");
   a_push_held: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("pushed item lost");
`endif

endmodule
